// ===== hw/rtl/llwd_pkg.sv =====
// Shared constants and types for the least-loaded worker dispatch block.
`default_nettype none

package llwd_pkg;

    // Number of workers held in the cell chain (1 .. 16, as chosen_worker is OUT_ID_W = 4 bits)
    localparam int NUM_WORKERS = 16;

    // Worker id width, at least one bit
    localparam int WID_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

    // Field widths
    localparam int LOAD_W   = 32;
    localparam int DUR_W    = 16;
    localparam int CFG_W    = 5;
    localparam int OUT_ID_W = 4;

    // Width used to compare a worker id against the active count
    localparam int CMP_W = ((WID_W > CFG_W) ? WID_W : CFG_W) + 1;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;
    localparam int M_PAD_W   = M_TDATA_W - OUT_ID_W - LOAD_W;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              found;
        logic [LOAD_W-1:0] load;
        logic [WID_W-1:0]  id;
    } t_token;

    // Load update broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [WID_W-1:0]  id;
        logic [LOAD_W-1:0] load;
    } t_wr;

endpackage

`default_nettype wire

// ===== hw/rtl/least_loaded_worker_dispatch_core.sv =====
// Top level of the least-loaded worker dispatch block.
// Each beat on s_axis carries a task duration; the block returns one beat on m_axis with the
// id of the active worker that had the smallest workload (lowest id on a tie) and that
// worker's new workload, saturated at 0xFFFFFFFF. Workloads start at zero after reset.
// i_cfg_data sets the number of active workers (ids 0 upward, reset value 1, values above
// NUM_WORKERS act as NUM_WORKERS); with zero active workers the result carries the no-worker
// flag in m_axis_tuser, zero data, and no workload changes. The minimum token walks the chain
// of worker cells one cell per cycle, the first cell on the accept edge itself; the result is
// then held and, once the output register is free, registered with the workload update. A
// no-worker item goes straight to that hold and update step. The next item is taken the cycle
// after the result is registered, while that result may still wait on m_axis_tready.
// Configuration must be written only while no item is in flight; the block does not enforce it.
`default_nettype none

module least_loaded_worker_dispatch_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [llwd_pkg::CFG_W-1:0]     i_cfg_data,     // active_workers
    // task input
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [llwd_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [15:0] task_duration
    // dispatch result
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [llwd_pkg::M_TDATA_W-1:0]      m_axis_tdata,   // [3:0] chosen_worker,
                                                                // [35:4] updated_load, pad
    output logic [llwd_pkg::M_TUSER_W-1:0]      m_axis_tuser    // [0] no_worker
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    t_state                          r_state;
    logic [llwd_pkg::CFG_W-1:0]      r_active;
    logic [llwd_pkg::DUR_W-1:0]      r_dur;
    logic                            r_hold_nw;
    logic [llwd_pkg::WID_W-1:0]      r_hold_id;
    logic [llwd_pkg::LOAD_W-1:0]     r_hold_load;
    logic                            r_m_valid;
    logic [llwd_pkg::M_TDATA_W-1:0]  r_m_data;
    logic [llwd_pkg::M_TUSER_W-1:0]  r_m_user;

    logic                            s_accept;
    logic                            out_free;
    logic [llwd_pkg::LOAD_W:0]       sum;
    logic [llwd_pkg::LOAD_W-1:0]     sat_load;
    llwd_pkg::t_token                tok [llwd_pkg::NUM_WORKERS+1];
    llwd_pkg::t_wr                   wr;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // token injected into the first cell on accept
    assign tok[0] = '{vld: s_accept && (r_active != '0), found: 1'b0, load: '0, id: '0};

    // chain of worker cells
    for (genvar g = 0; g < llwd_pkg::NUM_WORKERS; g++) begin : g_cell
        llwd_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (llwd_pkg::WID_W'(g)),
            .i_active  (r_active),
            .i_tok     (tok[g]),
            .i_wr      (wr),
            .o_tok     (tok[g+1])
        );
    end

    // saturating add of the task duration
    assign sum      = {1'b0, r_hold_load} + (llwd_pkg::LOAD_W + 1)'(r_dur);
    assign sat_load = sum[llwd_pkg::LOAD_W] ? '1 : sum[llwd_pkg::LOAD_W-1:0];

    // write back the chosen worker's load when the result is registered
    always_comb begin
        wr.en   = (r_state == ST_COMMIT) && out_free && !r_hold_nw;
        wr.id   = r_hold_id;
        wr.load = sat_load;
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= llwd_pkg::CFG_W'(1);
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_dur <= s_axis_tdata[llwd_pkg::DUR_W-1:0];
                        if (r_active == '0) begin
                            r_hold_nw   <= 1'b1;
                            r_hold_id   <= '0;
                            r_hold_load <= '0;
                            r_state     <= ST_COMMIT;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (tok[llwd_pkg::NUM_WORKERS].vld) begin
                        r_hold_nw   <= 1'b0;
                        r_hold_id   <= tok[llwd_pkg::NUM_WORKERS].id;
                        r_hold_load <= tok[llwd_pkg::NUM_WORKERS].load;
                        r_state     <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= llwd_pkg::M_TUSER_W'(r_hold_nw);
                        if (r_hold_nw) begin
                            r_m_data <= '0;
                        end else begin
                            r_m_data <= {{llwd_pkg::M_PAD_W{1'b0}}, sat_load,
                                         llwd_pkg::OUT_ID_W'(r_hold_id)};
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

`default_nettype wire

// ===== hw/rtl/llwd_cell.sv =====
// One worker cell: holds a workload and folds it into the passing minimum token.
`default_nettype none

module llwd_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [llwd_pkg::WID_W-1:0] i_cell_id,
    input  wire logic [llwd_pkg::CFG_W-1:0] i_active,
    input  wire llwd_pkg::t_token           i_tok,
    input  wire llwd_pkg::t_wr              i_wr,
    output llwd_pkg::t_token                o_tok
);

    logic [llwd_pkg::LOAD_W-1:0] r_load;
    llwd_pkg::t_token            r_tok;
    llwd_pkg::t_token            n_tok;
    logic                        cell_active;

    // worker takes part when its id is below the active count
    assign cell_active = (llwd_pkg::CMP_W'(i_cell_id) < llwd_pkg::CMP_W'(i_active));

    // take over the token on a strictly smaller load; first active cell always wins
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && cell_active && (!i_tok.found || (r_load < i_tok.load))) begin
            n_tok.found = 1'b1;
            n_tok.load  = r_load;
            n_tok.id    = i_cell_id;
        end
    end

    // workload storage and token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load    <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && (i_wr.id == i_cell_id)) begin
                r_load <= i_wr.load;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== hw/rtl/llwd_checker.sv =====
// Port-level checks for the least-loaded worker dispatch block, bound to the top level.
`default_nettype none

module llwd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [llwd_pkg::CFG_W-1:0]     i_cfg_data,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [llwd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [llwd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [llwd_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    // reset leaves no result pending
    a_rst_no_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // one item in flight: input closes after a beat is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    // a no-worker result carries zero id and load
    a_nw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("no-worker result with nonzero data");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind least_loaded_worker_dispatch_core llwd_checker u_llwd_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for least_loaded_worker_dispatch_core: task beats against a load model.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int          DRAIN_WAIT  = llwd_pkg::NUM_WORKERS + 8;
    localparam logic [llwd_pkg::DUR_W-1:0] DUR_MAX = {llwd_pkg::DUR_W{1'b1}};

    // One dispatch result as it leaves the block
    typedef struct packed {
        logic [llwd_pkg::OUT_ID_W-1:0] worker;
        logic [llwd_pkg::LOAD_W-1:0]   load;
        logic                          no_worker;
    } t_dispatch;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [llwd_pkg::CFG_W-1:0]          i_cfg_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [llwd_pkg::S_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [llwd_pkg::M_TDATA_W-1:0]      m_axis_tdata;
    logic [llwd_pkg::M_TUSER_W-1:0]      m_axis_tuser;

    // Load model: per-worker workloads and the active worker count
    logic [llwd_pkg::LOAD_W-1:0]         worker_load [llwd_pkg::NUM_WORKERS];
    logic [llwd_pkg::CFG_W-1:0]          active_cnt = llwd_pkg::CFG_W'(1);
    t_dispatch                           pending_dispatches [$];

    int unsigned                         error_cnt = 0;
    int unsigned                         cycle_cnt = 0;
    int unsigned                         stall_left = 0;
    bit                                  idling_on = 1'b1;

    least_loaded_worker_dispatch_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Pick the least-loaded active worker, charge it, and return the result
    function automatic t_dispatch predict_dispatch(input logic [llwd_pkg::DUR_W-1:0] dur);
        t_dispatch                     res;
        int unsigned                   cnt;
        int unsigned                   best;
        int unsigned                   i;
        logic [llwd_pkg::LOAD_W:0]     sum;
        res = '0;
        cnt = (active_cnt > llwd_pkg::NUM_WORKERS) ? llwd_pkg::NUM_WORKERS : active_cnt;
        if (cnt == 0) begin
            res.no_worker = 1'b1;
            return res;
        end
        best = 0;
        // strict compare keeps the lowest id on ties
        for (i = 1; i < cnt; i++) begin
            if (worker_load[i] < worker_load[best]) begin
                best = i;
            end
        end
        sum = {1'b0, worker_load[best]} + (llwd_pkg::LOAD_W + 1)'(dur);
        if (sum[llwd_pkg::LOAD_W]) begin
            sum = {1'b0, {llwd_pkg::LOAD_W{1'b1}}};
        end
        worker_load[best] = sum[llwd_pkg::LOAD_W-1:0];
        res.worker = llwd_pkg::OUT_ID_W'(best);
        res.load   = sum[llwd_pkg::LOAD_W-1:0];
        return res;
    endfunction

    initial begin
        for (int k = 0; k < llwd_pkg::NUM_WORKERS; k++) begin
            worker_load[k] = '0;
        end
    end

    // Result check, config tracking, and prediction on accepted beats
    always @(posedge i_clk) begin
        t_dispatch exp_d;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_dispatches.size() == 0) begin
                    $error("unexpected result beat: tdata %h tuser %h",
                           m_axis_tdata, m_axis_tuser);
                    error_cnt++;
                end else begin
                    exp_d = pending_dispatches.pop_front();
                    if (m_axis_tdata[llwd_pkg::OUT_ID_W-1:0] !== exp_d.worker) begin
                        $error("chosen_worker: expected %0d, got %0d",
                               exp_d.worker, m_axis_tdata[llwd_pkg::OUT_ID_W-1:0]);
                        error_cnt++;
                    end
                    if (m_axis_tdata[llwd_pkg::OUT_ID_W +: llwd_pkg::LOAD_W] !== exp_d.load)
                    begin
                        $error("updated_load: expected %h, got %h",
                               exp_d.load,
                               m_axis_tdata[llwd_pkg::OUT_ID_W +: llwd_pkg::LOAD_W]);
                        error_cnt++;
                    end
                    if (m_axis_tuser[0] !== exp_d.no_worker) begin
                        $error("no_worker: expected %0d, got %0d",
                               exp_d.no_worker, m_axis_tuser[0]);
                        error_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                active_cnt = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_dispatches.insert(pending_dispatches.size(),
                    predict_dispatch(s_axis_tdata[llwd_pkg::DUR_W-1:0]));
            end
        end
    end

    // Result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!idling_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(1, 18) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Send one task beat; may drop valid for a random gap afterwards
    task automatic send_task_duration(input logic [llwd_pkg::DUR_W-1:0] dur);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= llwd_pkg::S_TDATA_W'(dur);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Wait for all results, then let the block settle before a register write
    task automatic set_active_workers(input logic [llwd_pkg::CFG_W-1:0] cnt);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_dispatches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random duration: extremes, small values, full range
    function automatic logic [llwd_pkg::DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DUR_MAX;
            2, 3:    return llwd_pkg::DUR_W'($urandom_range(0, 15));
            default: return llwd_pkg::DUR_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Reset value of one active worker: everything lands on worker 0
    task automatic test_reset_config();
        send_task_duration('0);
        send_task_duration(DUR_MAX);
        send_task_duration(llwd_pkg::DUR_W'(1));
    endtask

    // Zero active workers: flag raised, loads untouched
    task automatic test_no_worker();
        set_active_workers('0);
        send_task_duration(DUR_MAX);
        send_task_duration('0);
        send_task_duration(llwd_pkg::DUR_W'(16'hA5A5));
    endtask

    // Full set with workers 1 and up at equal loads: lowest id wins each tie
    task automatic test_tie_order();
        set_active_workers(llwd_pkg::CFG_W'(llwd_pkg::NUM_WORKERS));
        send_task_duration('0);
        send_task_duration(llwd_pkg::DUR_W'(5));
        send_task_duration(llwd_pkg::DUR_W'(5));
        send_task_duration(llwd_pkg::DUR_W'(16'h5A5A));
        send_task_duration(llwd_pkg::DUR_W'(3));
        send_task_duration(DUR_MAX);
    endtask

    // Counts above the worker total act as the full set
    task automatic test_over_range_count();
        set_active_workers({llwd_pkg::CFG_W{1'b1}});
        send_task_duration(llwd_pkg::DUR_W'(2));
        send_task_duration(llwd_pkg::DUR_W'(2));
        send_task_duration(llwd_pkg::DUR_W'(7));
        set_active_workers(llwd_pkg::CFG_W'(llwd_pkg::NUM_WORKERS + 1));
        send_task_duration(llwd_pkg::DUR_W'(1));
        send_task_duration(llwd_pkg::DUR_W'(9));
    endtask

    // Loads of workers leaving the set are kept and count again on return
    task automatic test_shrink_grow();
        set_active_workers(llwd_pkg::CFG_W'(2));
        send_task_duration(llwd_pkg::DUR_W'(100));
        send_task_duration(llwd_pkg::DUR_W'(100));
        set_active_workers(llwd_pkg::CFG_W'(llwd_pkg::NUM_WORKERS));
        send_task_duration(llwd_pkg::DUR_W'(4));
        send_task_duration(llwd_pkg::DUR_W'(4));
    endtask

    // Random durations over a series of active counts
    task automatic test_random_dispatch();
        logic [llwd_pkg::CFG_W-1:0] cnt;
        int                         n_phases;
        n_phases = 12;
        for (int p = 0; p < n_phases; p++) begin
            case (p)
                0:       cnt = llwd_pkg::CFG_W'(llwd_pkg::NUM_WORKERS);
                1:       cnt = llwd_pkg::CFG_W'(1);
                2:       cnt = '0;
                3:       cnt = {llwd_pkg::CFG_W{1'b1}};
                4:       cnt = llwd_pkg::CFG_W'(3);
                5:       cnt = llwd_pkg::CFG_W'(llwd_pkg::NUM_WORKERS + 1);
                default: cnt = llwd_pkg::CFG_W'($urandom_range(0, 31));
            endcase
            set_active_workers(cnt);
            // every third phase runs with no idling on either side
            idling_on = (p % 3 != 2);
            repeat (54) send_task_duration(pick_duration());
        end
        idling_on = 1'b1;
    endtask

    // Closing stretch on the full set with no idling on either side
    task automatic test_back_to_back();
        set_active_workers(llwd_pkg::CFG_W'(llwd_pkg::NUM_WORKERS));
        idling_on = 1'b0;
        repeat (32) send_task_duration(pick_duration());
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_no_worker();
        test_tie_order();
        test_over_range_count();
        test_shrink_grow();
        test_random_dispatch();
        test_back_to_back();

        // drain outstanding results, then settle
        @(posedge i_clk);
        while (pending_dispatches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/llwd_pkg.sv
hw/rtl/llwd_cell.sv
hw/rtl/least_loaded_worker_dispatch_core.sv
hw/rtl/llwd_checker.sv
bench/tb.sv
